// File: src/uart_lite_fifo_registers_defines.svh
// Assertion macros shared by the UART register block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef UART_LITE_FIFO_REGISTERS_DEFINES_SVH
`define UART_LITE_FIFO_REGISTERS_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ULF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ULF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ulf_pkg.sv
// Shared types and constants of the UART register block.
// No dependencies; ulf_fifo, ulf_decode and the top level import this package.
`default_nettype none

package ulf_pkg;

	// Default depth of both byte FIFOs.
	localparam int FIFO_DEPTH_DEF = 8;

	// Item kinds.
	localparam logic [1:0] KIND_READ    = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_RX_BYTE = 2'd2;
	localparam logic [1:0] KIND_TX_DONE = 2'd3;

	// Register word addresses.
	localparam logic [1:0] ADDR_RX_DATA = 2'd0;
	localparam logic [1:0] ADDR_TX_DATA = 2'd1;
	localparam logic [1:0] ADDR_STATUS  = 2'd2;
	localparam logic [1:0] ADDR_CONTROL = 2'd3;

	// Status word bit positions.
	localparam int ST_RX_DATA  = 0;
	localparam int ST_RX_FULL  = 1;
	localparam int ST_TX_EMPTY = 2;
	localparam int ST_TX_FULL  = 3;
	localparam int ST_INTR_EN  = 4;

	// Control word bit positions.
	localparam int CTL_FLUSH_TX = 0;
	localparam int CTL_FLUSH_RX = 1;
	localparam int CTL_INTR_EN  = 4;

	// One input item.
	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] address;
		logic [7:0] write_data;
		logic [7:0] rx_byte;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_pulse;
		logic       tx_start;
		logic [7:0] tx_byte;
		logic       dropped;
	} result_t;

	// Commands from the decoder to one FIFO.
	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
	} fifo_cmd_t;

	// Status of one FIFO as seen by the decoder.
	typedef struct packed {
		logic       empty;
		logic       full;
		logic       single;
		logic [7:0] head;
		logic [7:0] second;
	} fifo_stat_t;

endpackage

`default_nettype wire

// File: src/ulf_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
// The payload type comes from ulf_pkg at the point of instantiation.
`default_nettype none

interface ulf_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/ulf_fifo.sv
// Byte FIFO with head and second-entry prefetch registers.
// Depends on ulf_pkg for the command and status structs.
`default_nettype none

module ulf_fifo
	import ulf_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire fifo_cmd_t  cmd,
	input  wire logic [7:0] wdata,
	output fifo_stat_t      stat
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [7:0]       mem [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, head_n, tail_n, second_addr;
	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       head_data_q, second_data_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// Next pointer and count values.
	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		if (cmd.flush) begin
			head_n  = '0;
			tail_n  = '0;
			count_n = '0;
		end else begin
			if (cmd.push) begin
				tail_n = ptr_inc(tail_q);
			end
			if (cmd.pop) begin
				head_n = ptr_inc(head_q);
			end
			case ({cmd.push, cmd.pop})
				2'b10:   count_n = count_q + CNT_ONE;
				2'b01:   count_n = count_q - CNT_ONE;
				default: count_n = count_q;
			endcase
		end
	end

	assign second_addr = ptr_inc(head_n);

	// Pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end

	// Storage write and registered reads of the next head and the entry behind it.
	// A write to the address being read is forwarded.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= wdata;
		end
		head_data_q   <= (cmd.push && tail_q == head_n) ? wdata : mem[head_n];
		second_data_q <= (cmd.push && tail_q == second_addr) ? wdata : mem[second_addr];
	end

	// Status toward the decoder.
	always_comb begin
		stat.empty  = (count_q == '0);
		stat.full   = (count_q == CNT_FULL);
		stat.single = (count_q == CNT_ONE);
		stat.head   = head_data_q;
		stat.second = second_data_q;
	end
endmodule

`default_nettype wire

// File: src/ulf_decode.sv
// Item decoder: works out the result, FIFO commands and next control state.
// Depends on ulf_pkg; purely combinational.
`default_nettype none

module ulf_decode
	import ulf_pkg::*;
(
	input  wire item_t      item,
	input  wire fifo_stat_t rx_stat,
	input  wire fifo_stat_t tx_stat,
	input  wire logic       irq_en,
	input  wire logic       busy,
	output result_t         res,
	output fifo_cmd_t       rx_cmd,
	output fifo_cmd_t       tx_cmd,
	output logic            irq_en_n,
	output logic            busy_n
);
	always_comb begin
		res      = '0;
		rx_cmd   = '0;
		tx_cmd   = '0;
		irq_en_n = irq_en;
		busy_n   = busy;
		case (item.kind)
			// Bus read: pop receive data or return status.
			KIND_READ: begin
				if (item.address == ADDR_RX_DATA) begin
					if (!rx_stat.empty) begin
						res.read_data = rx_stat.head;
						rx_cmd.pop    = 1'b1;
					end
				end else if (item.address == ADDR_STATUS) begin
					res.read_data[ST_RX_DATA]  = !rx_stat.empty;
					res.read_data[ST_RX_FULL]  = rx_stat.full;
					res.read_data[ST_TX_EMPTY] = tx_stat.empty;
					res.read_data[ST_TX_FULL]  = tx_stat.full;
					res.read_data[ST_INTR_EN]  = irq_en;
				end
			end
			// Bus write: push transmit data or update control.
			KIND_WRITE: begin
				if (item.address == ADDR_TX_DATA) begin
					if (tx_stat.full) begin
						res.dropped = 1'b1;
					end else begin
						tx_cmd.push = 1'b1;
						if (!busy) begin
							busy_n       = 1'b1;
							res.tx_start = 1'b1;
							res.tx_byte  = tx_stat.empty ? item.write_data : tx_stat.head;
						end
					end
				end else if (item.address == ADDR_CONTROL) begin
					rx_cmd.flush = item.write_data[CTL_FLUSH_RX];
					tx_cmd.flush = item.write_data[CTL_FLUSH_TX];
					if (item.write_data[CTL_FLUSH_TX]) begin
						busy_n = 1'b0;
					end
					irq_en_n = item.write_data[CTL_INTR_EN];
				end
			end
			// Serial byte arrived: push it, interrupt on the first entry.
			KIND_RX_BYTE: begin
				if (rx_stat.full) begin
					res.dropped = 1'b1;
				end else begin
					rx_cmd.push   = 1'b1;
					res.irq_pulse = irq_en && rx_stat.empty;
				end
			end
			// Transmitter done: pop the sent byte, start the next or go idle.
			KIND_TX_DONE: begin
				if (busy) begin
					tx_cmd.pop = !tx_stat.empty;
					if (!tx_stat.empty && !tx_stat.single) begin
						res.tx_start = 1'b1;
						res.tx_byte  = tx_stat.second;
					end else begin
						busy_n        = 1'b0;
						res.irq_pulse = irq_en;
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end
endmodule

`default_nettype wire

// File: src/uart_lite_fifo_registers.sv
// Top level of the UART register block with receive and transmit byte FIFOs.
// Depends on ulf_pkg, ulf_chan_if, ulf_fifo, ulf_decode and the assertion macros.
//
// Usage:
// - The item channel carries one event per transfer: a bus read, a bus write,
//   a byte received from the serial line, or the transmitter finishing a byte.
// - The result channel returns exactly one result per item: read data, an
//   interrupt pulse, a transmitter start with its byte, and a drop flag.
// - An accepted item is held in the input register, where the decoder and
//   both FIFOs act on it; its result is then held in the output register.
//   Result valid rises when the item moves from the input register into the
//   output register, which waits while an untaken result is still held there.
// - One item per cycle is sustained while results are taken. The FIFO storage
//   reads are registered and prefetch the head and the entry behind it, so
//   each item completes in a single pass through the decoder.
// - If the receiver stalls, the result is held, the input register keeps its
//   item, and the item channel deasserts ready once both are occupied.
// - Reset empties both FIFOs, clears interrupt enable and marks the line idle.
//   No clearing pass is needed; the block takes items right after reset.
`default_nettype none
`include "uart_lite_fifo_registers_defines.svh"

module uart_lite_fifo_registers
	import ulf_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ulf_chan_if.sink   item,
	ulf_chan_if.source result
);
	item_t      item_s1;
	logic       valid_s1;
	result_t    result_q;
	logic       result_valid_q;
	logic       irq_en_q, busy_q;
	logic       advance;
	result_t    res_n;
	fifo_cmd_t  rx_cmd, tx_cmd, rx_cmd_g, tx_cmd_g;
	fifo_stat_t rx_stat, tx_stat;
	logic       irq_en_n, busy_n;

	// The input register moves on when the output register is free or drains.
	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	ulf_decode u_decode (
		.item     (item_s1),
		.rx_stat  (rx_stat),
		.tx_stat  (tx_stat),
		.irq_en   (irq_en_q),
		.busy     (busy_q),
		.res      (res_n),
		.rx_cmd   (rx_cmd),
		.tx_cmd   (tx_cmd),
		.irq_en_n (irq_en_n),
		.busy_n   (busy_n)
	);

	// FIFO commands take effect only when the item completes.
	assign rx_cmd_g = advance ? rx_cmd : '0;
	assign tx_cmd_g = advance ? tx_cmd : '0;

	ulf_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rx_cmd_g),
		.wdata  (item_s1.rx_byte),
		.stat   (rx_stat)
	);

	ulf_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tx_cmd_g),
		.wdata  (item_s1.write_data),
		.stat   (tx_stat)
	);

	// Interrupt enable and transmitter line state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q <= 1'b0;
			busy_q   <= 1'b0;
		end else if (advance) begin
			irq_en_q <= irq_en_n;
			busy_q   <= busy_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_n;
		end
	end

	assign result.valid = result_valid_q;
	assign result.data  = result_q;

	// A busy line always has its byte at the head of the transmit FIFO.
	`ULF_ASSERT_SAME(a_busy_not_empty, busy_q, !tx_stat.empty, "line busy with empty tx FIFO")
	// Starting a byte leaves the line busy.
	`ULF_ASSERT_NEXT(a_start_sets_busy, advance && res_n.tx_start, busy_q, "tx start left line idle")
	// Interrupts only fire while enabled.
	`ULF_ASSERT_SAME(a_irq_needs_en, advance && res_n.irq_pulse, irq_en_q, "irq while disabled")
endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UART register block with its two byte FIFOs.
// Depends on ulf_pkg, ulf_chan_if and the uart_lite_fifo_registers RTL.

module testbench;
	import ulf_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_ITEMS  = 100;
	localparam int HOLD_CYCLES  = 80;

	logic clk;
	logic arst_n;

	ulf_chan_if #(.T(item_t))   item_ch ();
	ulf_chan_if #(.T(result_t)) result_ch ();

	uart_lite_fifo_registers u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Items waiting for the driver and results the block still owes.
	item_t   pending_items[$];
	result_t expected_results[$];

	// Shadow copy of the block state.
	logic [7:0] shadow_tx_fifo[$];
	logic [7:0] shadow_rx_fifo[$];
	bit         shadow_irq_en;
	bit         shadow_line_busy;

	int  queued_count;
	int  accepted_count;
	int  mismatches;
	int  cycle_count;
	int  send_idle_pct;
	int  stall_pct;
	int  phase_no;
	bit  hold_results;
	bit  item_fired;

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Works out the result of one item and advances the shadow state.
	function automatic result_t predict_uart(input item_t it);
		result_t r;
		r = '0;
		case (it.kind)
			KIND_READ: begin
				if (it.address == ADDR_RX_DATA) begin
					if (shadow_rx_fifo.size() > 0)
						r.read_data = shadow_rx_fifo.pop_front();
				end else if (it.address == ADDR_STATUS) begin
					r.read_data[ST_RX_DATA]  = shadow_rx_fifo.size() > 0;
					r.read_data[ST_RX_FULL]  = shadow_rx_fifo.size() >= FIFO_DEPTH_DEF;
					r.read_data[ST_TX_EMPTY] = shadow_tx_fifo.size() == 0;
					r.read_data[ST_TX_FULL]  = shadow_tx_fifo.size() >= FIFO_DEPTH_DEF;
					r.read_data[ST_INTR_EN]  = shadow_irq_en;
				end
			end
			KIND_WRITE: begin
				if (it.address == ADDR_TX_DATA) begin
					if (shadow_tx_fifo.size() >= FIFO_DEPTH_DEF) begin
						r.dropped = 1'b1;
					end else begin
						shadow_tx_fifo.push_back(it.write_data);
						if (!shadow_line_busy) begin
							shadow_line_busy = 1'b1;
							r.tx_start = 1'b1;
							r.tx_byte = shadow_tx_fifo[0];
						end
					end
				end else if (it.address == ADDR_CONTROL) begin
					if (it.write_data[CTL_FLUSH_RX])
						shadow_rx_fifo.delete();
					if (it.write_data[CTL_FLUSH_TX]) begin
						shadow_tx_fifo.delete();
						shadow_line_busy = 1'b0;
					end
					shadow_irq_en = it.write_data[CTL_INTR_EN];
				end
			end
			KIND_RX_BYTE: begin
				if (shadow_rx_fifo.size() >= FIFO_DEPTH_DEF) begin
					r.dropped = 1'b1;
				end else begin
					shadow_rx_fifo.push_back(it.rx_byte);
					r.irq_pulse = shadow_irq_en && shadow_rx_fifo.size() == 1;
				end
			end
			default: begin
				// Transmitter done: pop the byte on the line, start the next or go idle.
				if (shadow_line_busy) begin
					void'(shadow_tx_fifo.pop_front());
					if (shadow_tx_fifo.size() > 0) begin
						r.tx_start = 1'b1;
						r.tx_byte = shadow_tx_fifo[0];
					end else begin
						shadow_line_busy = 1'b0;
						r.irq_pulse = shadow_irq_en;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	function automatic item_t make_item(input logic [1:0] kind, input logic [1:0] address,
			input logic [7:0] write_data, input logic [7:0] rx_byte);
		item_t it;
		it.kind = kind;
		it.address = address;
		it.write_data = write_data;
		it.rx_byte = rx_byte;
		return it;
	endfunction

	task automatic queue_item(input item_t it);
		pending_items.push_back(it);
		queued_count++;
	endtask

	// Random event, weighted so that both FIFOs fill and drain often.
	function automatic item_t make_random_item();
		item_t it;
		int pick;
		it.write_data = 8'($urandom);
		it.rx_byte = 8'($urandom);
		it.address = 2'($urandom);
		pick = $urandom_range(99);
		if (pick < 30) begin
			it.kind = KIND_WRITE;
			pick = $urandom_range(99);
			if (pick < 65)
				it.address = ADDR_TX_DATA;
			else if (pick < 85)
				it.address = ADDR_CONTROL;
			// Flushes are kept rare so that the FIFOs get deep.
			if (it.address == ADDR_CONTROL && $urandom_range(7) != 0) begin
				it.write_data[CTL_FLUSH_TX] = 1'b0;
				it.write_data[CTL_FLUSH_RX] = 1'b0;
			end
		end else if (pick < 55) begin
			it.kind = KIND_RX_BYTE;
		end else if (pick < 75) begin
			it.kind = KIND_TX_DONE;
		end else begin
			it.kind = KIND_READ;
		end
		return it;
	endfunction

	// Waits until every queued item has made its transfer and every result has come.
	task automatic wait_drained();
		while (accepted_count != queued_count || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Item driver: offers the next pending item, with random idle cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_ch.valid || item_fired) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item_ch.valid <= 1'b1;
					item_ch.data <= pending_items.pop_front();
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= !hold_results && $urandom_range(99) >= stall_pct;
		end
	end

	// Monitor: predicts on each item transfer and checks each result transfer.
	always @(posedge clk) begin
		result_t want;
		item_fired <= arst_n && item_ch.valid && item_ch.ready;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			expected_results.push_back(predict_uart(item_ch.data));
			accepted_count++;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item outstanding",
						result_ch.data.read_data, 8'h00);
			end else begin
				want = expected_results.pop_front();
				check_field("read_data", result_ch.data.read_data, want.read_data);
				check_field("irq_pulse", 8'(result_ch.data.irq_pulse), 8'(want.irq_pulse));
				check_field("tx_start", 8'(result_ch.data.tx_start), 8'(want.tx_start));
				check_field("tx_byte", result_ch.data.tx_byte, want.tx_byte);
				check_field("dropped", 8'(result_ch.data.dropped), 8'(want.dropped));
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Long receiver hold-off in the first random phase, so the block backs up.
	initial begin
		hold_results = 1'b0;
		wait (phase_no == 1);
		repeat (20) @(posedge clk);
		hold_results = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results = 1'b0;
	end

	// Reset, directed items, then random phases with different idling.
	initial begin
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		phase_no = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty reads, write-only words read, read-only words written.
		queue_item(make_item(KIND_READ, ADDR_RX_DATA, 8'h00, 8'hFF));
		queue_item(make_item(KIND_READ, ADDR_STATUS, 8'hFF, 8'h00));
		queue_item(make_item(KIND_READ, ADDR_TX_DATA, 8'hFF, 8'hFF));
		queue_item(make_item(KIND_READ, ADDR_CONTROL, 8'hFF, 8'hFF));
		queue_item(make_item(KIND_WRITE, ADDR_CONTROL, 8'h10, 8'h00));
		queue_item(make_item(KIND_WRITE, ADDR_RX_DATA, 8'hFF, 8'h00));
		queue_item(make_item(KIND_WRITE, ADDR_STATUS, 8'hFF, 8'h00));
		// Receive FIFO from empty to full, then one byte too many.
		for (int i = 0; i <= FIFO_DEPTH_DEF; i++)
			queue_item(make_item(KIND_RX_BYTE, ADDR_RX_DATA, 8'h00,
					(i == 0) ? 8'h00 : 8'hFF - 8'(i)));
		queue_item(make_item(KIND_READ, ADDR_STATUS, 8'h00, 8'h00));
		queue_item(make_item(KIND_READ, ADDR_RX_DATA, 8'h00, 8'h00));
		// Transmit FIFO from empty to full, then one byte too many.
		for (int i = 0; i <= FIFO_DEPTH_DEF; i++)
			queue_item(make_item(KIND_WRITE, ADDR_TX_DATA,
					(i == 0) ? 8'hFF : 8'(i), 8'h00));
		queue_item(make_item(KIND_READ, ADDR_STATUS, 8'h00, 8'h00));
		queue_item(make_item(KIND_TX_DONE, ADDR_TX_DATA, 8'h00, 8'h00));
		// Flush both while the line is busy, then done while idle.
		queue_item(make_item(KIND_WRITE, ADDR_CONTROL, 8'h13, 8'h00));
		queue_item(make_item(KIND_TX_DONE, ADDR_TX_DATA, 8'h00, 8'h00));
		queue_item(make_item(KIND_WRITE, ADDR_TX_DATA, 8'hA5, 8'h00));
		queue_item(make_item(KIND_TX_DONE, ADDR_TX_DATA, 8'h00, 8'h00));
		queue_item(make_item(KIND_TX_DONE, ADDR_TX_DATA, 8'h00, 8'h00));
		queue_item(make_item(KIND_WRITE, ADDR_CONTROL, 8'h00, 8'h00));
		wait_drained();

		// Random phases; the sender pauses between them until all results are in.
		for (int p = 1; p <= 4; p++) begin
			phase_no = p;
			case (p)
				1: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 82;
					stall_pct = 0;
				end
				3: begin
					send_idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					send_idle_pct = 38;
					stall_pct = 38;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_item(make_random_item());
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/ulf_pkg.sv
src/ulf_chan_if.sv
src/ulf_fifo.sv
src/ulf_decode.sv
src/uart_lite_fifo_registers.sv
dv/testbench.sv
